### hdl/hbe_pkg.sv
`timescale 1ns / 1ps
package hbe_pkg;

    localparam int BINS_DEF        = 256;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [8:0]  BINS_IN_USE_RESET = 9'd256;
    localparam logic [31:0] TOTAL_MAX         = 32'hFFFF_FFFF;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_TAKE   = 3'd1;
    localparam logic [2:0] ACT_RANGE  = 3'd2;
    localparam logic [2:0] ACT_FULL   = 3'd3;
    localparam logic [2:0] ACT_ARGMAX = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] bin_index;
        logic [7:0] range_low;
        logic [8:0] range_high;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  value;
        logic [31:0] matched_count;
        logic [31:0] total_entries;
    } t_out;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic       inc;
        logic       dec;
        logic [7:0] idx;
    } t_cell_ctl;

endpackage

### hdl/hbe_cell.sv
`timescale 1ns / 1ps
module hbe_cell #(
    parameter int CW  = hbe_pkg::COUNT_WIDTH_DEF,
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbe_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_next,
    output logic [CW-1:0]      o_count
);

    localparam int HW = (IW > 8) ? IW : 8;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_hit;

    assign w_hit   = (HW'(i_ctl.idx) == HW'(IDX));
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.shift) begin
            n_count = i_next;
        end else if (w_hit && i_ctl.inc && (r_count != '1)) begin
            n_count = r_count + CW'(1);
        end else if (w_hit && i_ctl.dec && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### hdl/hbe_div.sv
`timescale 1ns / 1ps
module hbe_div #(
    parameter int SW = 32,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_quotient
);

    localparam int CNW = $clog2(SW + 1);

    logic [SW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_d;
    logic [CNW-1:0] r_cnt;
    logic           r_run;
    logic           r_done;
    logic [DW:0]    w_trial;
    logic           w_ge;

    assign w_trial    = {r_rem, r_q[SW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_d});
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_dividend;
                r_rem <= '0;
                r_d   <= i_divisor;
            end else if (r_run) begin
                r_q   <= {r_q[SW-2:0], w_ge};
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_d}) : DW'(w_trial);
                r_cnt <= r_cnt + CNW'(1);
                if (r_cnt == CNW'(SW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### hdl/histogram_bin_engine.sv
`timescale 1ns / 1ps
// Histogram of BINS saturating counters held in a ring of cells. A command is
// taken when i_start is high and o_busy is low, and its word appears on o_res
// for exactly one cycle with o_res_valid; the receiver cannot stall, so it
// must take every word as it comes. Add, take, clear, unused actions and
// queries on an empty total answer in the cycle after the command. Queries
// rotate the whole ring once, one bin per cycle, then drain a short
// multiply-accumulate pipeline before argmax answers, and both averages
// add a one-bit-per-cycle divider of COUNT_WIDTH + 2 * log2(BINS) steps
// (a range with no matching entries answers empty without it). o_busy stays
// high until the answer is issued. bins_in_use may be written only while idle.
module histogram_bin_engine #(
    parameter int BINS        = hbe_pkg::BINS_DEF,
    parameter int COUNT_WIDTH = hbe_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  hbe_pkg::t_in  i_cmd,
    output logic          o_res_valid,
    output hbe_pkg::t_out o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [8:0]    i_cfg_data
);

    localparam int CW   = COUNT_WIDTH;
    localparam int IW   = $clog2(BINS);
    localparam int NW   = (IW + 1 > 9) ? IW + 1 : 9;
    localparam int MW   = CW + IW;
    localparam int SW   = MW + IW;
    localparam int DW   = (MW > 32) ? MW : 32;
    localparam int LW   = (MW > 32) ? MW : 33;
    localparam int CMPW = (SW > NW) ? SW : NW;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV} t_state;

    t_state             r_state, n_state;
    hbe_pkg::t_in       r_cmd;
    hbe_pkg::t_out      r_res, n_res;
    logic               r_res_vld, n_res_vld;
    logic [31:0]        r_total, n_total;
    logic [31:0]        r_lm, n_lm;
    logic [8:0]         r_biu;
    logic [IW-1:0]      r_cnt, n_cnt;
    logic [1:0]         r_dcnt, n_dcnt;
    logic               r_v1, r_v2;
    logic [CW-1:0]      r_c1, r_c2, r_best_c;
    logic [IW-1:0]      r_i1, r_i2, r_best_i;
    logic [MW-1:0]      r_p2, r_match;
    logic [SW-1:0]      r_sum;
    hbe_pkg::t_cell_ctl w_ctl;
    logic [CW-1:0]      w_count [BINS];
    logic [NW-1:0]      w_n, w_nm1, w_scan_i;
    logic               w_acc, w_idx_ok, w_win, w_div_start, w_div_done;
    logic [DW-1:0]      w_divisor;
    logic [SW-1:0]      w_q;
    logic [LW-1:0]      w_m_ext;
    logic [31:0]        w_m_sat;
    logic [CMPW-1:0]    w_q_clamp;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    assign w_acc    = i_start && !o_busy;
    assign w_n      = (r_biu == 9'd0) ? NW'(1) :
                      ((NW'(r_biu) > NW'(BINS)) ? NW'(BINS) : NW'(r_biu));
    assign w_nm1    = w_n - NW'(1);
    assign w_idx_ok = NW'(i_cmd.bin_index) < w_n;
    assign w_scan_i = NW'(r_cnt);
    assign w_win    = (w_scan_i < w_n) && ((r_cmd.action != hbe_pkg::ACT_RANGE) ||
                      ((w_scan_i >= NW'(r_cmd.range_low)) &&
                       (w_scan_i < NW'(r_cmd.range_high))));

    assign w_ctl.shift = (r_state == ST_SCAN);
    assign w_ctl.clear = w_acc && (i_cmd.action == hbe_pkg::ACT_CLEAR);
    assign w_ctl.inc   = w_acc && (i_cmd.action == hbe_pkg::ACT_ADD) && w_idx_ok;
    assign w_ctl.dec   = w_acc && (i_cmd.action == hbe_pkg::ACT_TAKE) && w_idx_ok;
    assign w_ctl.idx   = i_cmd.bin_index;

    for (genvar k = 0; k < BINS; k++) begin : g_cell
        hbe_cell #(.CW(CW), .IW(IW), .IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_next  (w_count[(k + 1) % BINS]),
            .o_count (w_count[k])
        );
    end

    assign w_m_ext   = LW'(r_match);
    assign w_m_sat   = (w_m_ext > LW'(hbe_pkg::TOTAL_MAX)) ? hbe_pkg::TOTAL_MAX
                                                            : w_m_ext[31:0];
    assign w_divisor = (r_cmd.action == hbe_pkg::ACT_RANGE) ? DW'(r_match) : DW'(r_total);
    assign w_q_clamp = (CMPW'(w_q) > CMPW'(w_nm1)) ? CMPW'(w_nm1) : CMPW'(w_q);

    hbe_div #(.SW(SW), .DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_res_vld   = 1'b0;
        n_total     = r_total;
        n_lm        = r_lm;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_res.status = hbe_pkg::STS_OK;
                    n_res.value  = '0;
                    case (i_cmd.action)
                        hbe_pkg::ACT_ADD: begin
                            if (!w_idx_ok) begin
                                n_res.status = hbe_pkg::STS_RANGE;
                            end else if (r_total != hbe_pkg::TOTAL_MAX) begin
                                n_total = r_total + 32'd1;
                            end
                        end
                        hbe_pkg::ACT_TAKE: begin
                            if (!w_idx_ok) begin
                                n_res.status = hbe_pkg::STS_RANGE;
                            end else if (r_total != 32'd0) begin
                                n_total = r_total - 32'd1;
                            end
                        end
                        hbe_pkg::ACT_RANGE, hbe_pkg::ACT_FULL, hbe_pkg::ACT_ARGMAX: begin
                            if (r_total == 32'd0) begin
                                n_res.status = hbe_pkg::STS_EMPTY;
                                if (i_cmd.action != hbe_pkg::ACT_FULL) begin
                                    n_lm = 32'd0;
                                end
                            end else begin
                                n_state = ST_SCAN;
                                n_cnt   = '0;
                            end
                        end
                        hbe_pkg::ACT_CLEAR: begin
                            n_total = 32'd0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.matched_count = n_lm;
                    n_res.total_entries = n_total;
                    n_res_vld           = (n_state == ST_IDLE);
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == IW'(BINS - 1)) begin
                    n_state = ST_DRAIN;
                    n_dcnt  = 2'd0;
                end
            end
            ST_DRAIN: begin
                n_dcnt = r_dcnt + 2'd1;
                if (r_dcnt == 2'd2) begin
                    n_res.status        = hbe_pkg::STS_OK;
                    n_res.value         = '0;
                    n_res.total_entries = r_total;
                    case (r_cmd.action)
                        hbe_pkg::ACT_ARGMAX: begin
                            n_lm        = 32'(r_best_c);
                            n_res.value = 8'(r_best_i);
                            n_state     = ST_IDLE;
                            n_res_vld   = 1'b1;
                        end
                        hbe_pkg::ACT_RANGE: begin
                            n_lm = w_m_sat;
                            if (r_match == '0) begin
                                n_res.status = hbe_pkg::STS_EMPTY;
                                n_state      = ST_IDLE;
                                n_res_vld    = 1'b1;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = ST_DIV;
                            end
                        end
                        default: begin
                            n_lm        = r_total;
                            w_div_start = 1'b1;
                            n_state     = ST_DIV;
                        end
                    endcase
                    n_res.matched_count = n_lm;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res.value = (r_cmd.action == hbe_pkg::ACT_FULL) ? 8'(w_q_clamp)
                                                                       : 8'(w_q);
                    n_state     = ST_IDLE;
                    n_res_vld   = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_res_vld <= 1'b0;
            r_res     <= '0;
            r_total   <= '0;
            r_lm      <= '0;
            r_biu     <= hbe_pkg::BINS_IN_USE_RESET;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            r_res     <= n_res;
            r_total   <= n_total;
            r_lm      <= n_lm;
            r_cnt     <= n_cnt;
            r_dcnt    <= n_dcnt;
            r_v1      <= (r_state == ST_SCAN) && w_win;
            r_v2      <= r_v1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_biu <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd <= i_cmd;
        end
        r_c1 <= w_count[0];
        r_i1 <= r_cnt;
        r_p2 <= MW'(r_i1) * MW'(r_c1);
        r_c2 <= r_c1;
        r_i2 <= r_i1;
        if (w_acc) begin
            r_sum    <= '0;
            r_match  <= '0;
            r_best_c <= '0;
            r_best_i <= '0;
        end else if (r_v2) begin
            r_sum   <= r_sum + SW'(r_p2);
            r_match <= r_match + MW'(r_c2);
            if (r_c2 > r_best_c) begin
                r_best_c <= r_c2;
                r_best_i <= r_i2;
            end
        end
    end

`ifndef SYNTHESIS
    a_res_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != hbe_pkg::STS_OK)) |-> (o_res.value == 8'd0))
        else $error("value nonzero with a failing status");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_cnt == IW'(BINS - 1))) |=> (r_state == ST_DRAIN))
        else $error("ring scan did not end after one full turn");

    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) || (r_state == ST_DRAIN && r_dcnt != 2'd2)) |=> !o_res_valid)
        else $error("result word issued during a scan");
`endif

endmodule
